### hw/rtl/vll_pkg.sv
// Shared types and constants for the vertex Lambert lighting unit.
// Used by the datapath and the top level; depends on nothing.
package vll_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   // Register indexes, taken from paddr[5:3].
   localparam logic [2:0] REG_ROW_FIRST   = 3'd0;
   localparam logic [2:0] REG_ROW_SECOND  = 3'd1;
   localparam logic [2:0] REG_ROW_THIRD   = 3'd2;
   localparam logic [2:0] REG_LIGHT_DIR   = 3'd3;
   localparam logic [2:0] REG_AMBIENT     = 3'd4;
   localparam logic [2:0] REG_DIFFUSE     = 3'd5;

   localparam logic [47:0] ROW_FIRST_RST  = 48'd16384;
   localparam logic [47:0] ROW_SECOND_RST = 48'd1073741824;
   localparam logic [47:0] ROW_THIRD_RST  = 48'd70368744177664;
   localparam logic [47:0] LIGHT_DIR_RST  = 48'd58437860069362;
   localparam logic [15:0] AMBIENT_RST    = 16'd36045;
   localparam logic [15:0] DIFFUSE_RST    = 16'd49152;

   // Configuration as the datapath sees it; m is row major, entry 3*i+j.
   typedef struct packed {
      logic [8:0][15:0] m;
      logic [2:0][15:0] light;
      logic [15:0]      ambient;
      logic [15:0]      diffuse;
   } cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] normal;
      logic [15:0]      tex_u;
      logic [15:0]      tex_v;
      logic [2:0][31:0] offset;
      logic             chrome;
   } vtx_type;

   typedef struct packed {
      logic [2:0][31:0] out_pos;
      logic [7:0]       gray_level;
      logic [15:0]      out_u;
      logic [15:0]      out_v;
   } rsp_type;

   // Fields that ride along the pipeline untouched.
   typedef struct packed {
      logic [2:0][31:0] pos_sum;
      logic [15:0]      tex_u;
      logic [15:0]      tex_v;
      logic             chrome;
   } side_type;

   // Normalization and square root state.
   typedef struct packed {
      logic [63:0]      x;
      logic [63:0]      res;
      logic [2:0][31:0] a;
      logic [2:0]       neg;
      logic             zero;
   } mid_type;

endpackage

### hw/rtl/vll_datapath.sv
// Pipelined lighting datapath: rotate, normalize, light and place one vertex.
// Depends on vll_pkg; every stage advances on one shared enable.
module vll_datapath #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  vll_pkg::vtx_type vtx,
   input  vll_pkg::cfg_type cfg,
   input  logic             out_ready,
   output logic             advance,
   output logic             out_valid,
   output vll_pkg::rsp_type rsp
);
   import vll_pkg::*;

   localparam int F     = NORMAL_FRAC_BITS;
   localparam int NNORM = 5;
   localparam int NSQRT = 32;
   localparam int NDIV  = F + 1;
   localparam int ST_N  = 4;
   localparam int ST_S  = ST_N + NNORM;
   localparam int ST_D  = ST_S + NSQRT;
   localparam int ST_P  = ST_D + NDIV;
   localparam int TOTAL = ST_P + 4;
   localparam int NW    = F + 33;
   localparam int TW    = F + 40;
   localparam int TCW   = F + 17;
   localparam int GW    = F + 26;

   localparam logic signed [34:0] HALF_R  = 35'sd1 <<< (F - 1);
   localparam logic signed [F+19:0] HALF_D = (F + 20)'(1) <<< (F - 1);
   localparam logic signed [39:0] ONE_C   = 40'sd1 <<< F;
   localparam logic signed [TW-1:0] T_MAX = (TW)'(1) <<< (16 + F);
   localparam logic [GW-1:0] HALF_G       = (GW)'(1) << (15 + F);

   logic [TOTAL-1:0] v_ff;
   side_type         side_ff [TOTAL];

   assign advance   = !v_ff[TOTAL-1] || out_ready;
   assign out_valid = v_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[TOTAL-2:0], in_valid};
      end
   end

   side_type side_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side_in.pos_sum[i] = vtx.pos[i] + vtx.offset[i];
      end
      side_in.tex_u  = vtx.tex_u;
      side_in.tex_v  = vtx.tex_v;
      side_in.chrome = vtx.chrome;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < TOTAL; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage 0: the nine matrix products.
   logic signed [31:0] prod_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[3*i+j] <= $signed(cfg.m[3*i+j]) * $signed(vtx.normal[j]);
            end
         end
      end
   end

   // Stage 1: row sums rounded to F fraction bits, split into sign and magnitude.
   logic [2:0][31:0] a1_ff;
   logic [2:0]       neg1_ff;
   logic [2:0][31:0] a1_in;
   logic [2:0]       neg1_in;
   always_comb begin
      logic signed [34:0] sum;
      logic signed [34:0] r;
      logic signed [34:0] mag;
      for (int i = 0; i < 3; i++) begin
         sum = 35'(prod_ff[3*i]) + 35'(prod_ff[3*i+1]) + 35'(prod_ff[3*i+2]) + HALF_R;
         r   = sum >>> F;
         mag = r[34] ? -r : r;
         neg1_in[i] = r[34];
         a1_in[i]   = mag[31:0];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff   <= a1_in;
         neg1_ff <= neg1_in;
      end
   end

   // Stage 2: squares.
   logic [2:0][63:0] sq_ff;
   logic [2:0][31:0] a2_ff;
   logic [2:0]       neg2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= a1_ff[i] * a1_ff[i];
         end
         a2_ff   <= a1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: squared length.
   mid_type mid_ff [ST_N-1:ST_D-1];
   mid_type mid3_in;
   always_comb begin
      mid3_in.x    = sq_ff[0] + sq_ff[1] + sq_ff[2];
      mid3_in.res  = '0;
      mid3_in.a    = a2_ff;
      mid3_in.neg  = neg2_ff;
      mid3_in.zero = (mid3_in.x == 64'd0);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff[ST_N-1] <= mid3_in;
      end
   end

   // Normalization: shift the length left by an even count until one of its top
   // two bits is set, and the magnitudes by half that count, in halving steps.
   for (genvar g = 0; g < NNORM; g++) begin : g_norm
      localparam int K = 32 >> g;
      mid_type n_in;
      always_comb begin
         n_in = mid_ff[ST_N-1+g];
         if (n_in.x[63 -: K] == '0) begin
            n_in.x = n_in.x << K;
            for (int i = 0; i < 3; i++) begin
               n_in.a[i] = n_in.a[i] << (K / 2);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            mid_ff[ST_N+g] <= n_in;
         end
      end
   end

   // Square root, one result bit per stage.
   for (genvar g = 0; g < NSQRT; g++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
      mid_type s_in;
      always_comb begin
         logic [63:0] trial;
         s_in  = mid_ff[ST_S-1+g];
         trial = s_in.res + BIT;
         if (s_in.x >= trial) begin
            s_in.x   = s_in.x - trial;
            s_in.res = (s_in.res >> 1) + BIT;
         end else begin
            s_in.res = s_in.res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            mid_ff[ST_S+g] <= s_in;
         end
      end
   end

   // Three restoring dividers, one quotient bit per stage.
   logic [2:0][31:0] rem_ff [NDIV];
   logic [2:0][F:0]  nb_ff  [NDIV];
   logic [2:0][F:0]  quo_ff [NDIV];
   logic [31:0]      q_ff   [NDIV];
   logic [3:0]       flag_ff [NDIV];

   logic [2:0][31:0] rem_init;
   logic [2:0][F:0]  nb_init;
   logic [31:0]      q_init;
   always_comb begin
      logic [NW-1:0] num;
      q_init = mid_ff[ST_D-1].res[31:0];
      for (int i = 0; i < 3; i++) begin
         num = {1'b0, mid_ff[ST_D-1].a[i], {F{1'b0}}} + (NW)'(q_init >> 1);
         rem_init[i] = num[NW-1:F+1];
         nb_init[i]  = num[F:0];
      end
   end

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      logic [2:0][31:0] r_src;
      logic [2:0][F:0]  n_src;
      logic [2:0][F:0]  o_src;
      logic [31:0]      q_src;
      logic [3:0]       f_src;
      logic [2:0][31:0] r_in;
      logic [2:0][F:0]  n_in;
      logic [2:0][F:0]  o_in;
      if (g == 0) begin : g_first
         assign r_src = rem_init;
         assign n_src = nb_init;
         assign o_src = '0;
         assign q_src = q_init;
         assign f_src = {mid_ff[ST_D-1].neg, mid_ff[ST_D-1].zero};
      end else begin : g_next
         assign r_src = rem_ff[g-1];
         assign n_src = nb_ff[g-1];
         assign o_src = quo_ff[g-1];
         assign q_src = q_ff[g-1];
         assign f_src = flag_ff[g-1];
      end
      always_comb begin
         logic [32:0] t;
         logic        ge;
         for (int i = 0; i < 3; i++) begin
            t  = {r_src[i], n_src[i][F]};
            ge = (t >= {1'b0, q_src});
            r_in[i] = ge ? 32'(t - {1'b0, q_src}) : t[31:0];
            n_in[i] = n_src[i] << 1;
            o_in[i] = {o_src[i][F-1:0], ge};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g]  <= r_in;
            nb_ff[g]   <= n_in;
            quo_ff[g]  <= o_in;
            q_ff[g]    <= q_src;
            flag_ff[g] <= f_src;
         end
      end
   end

   // Unit normal times light direction.
   logic signed [F+17:0] lp_ff [3];
   logic signed [F+1:0]  u0_ff, u1_ff;
   always_ff @(posedge clock) begin
      logic signed [F+1:0] u [3];
      logic [3:0]          fl;
      fl = flag_ff[NDIV-1];
      for (int i = 0; i < 3; i++) begin
         if (fl[0]) begin
            u[i] = '0;
         end else if (fl[i+1]) begin
            u[i] = -$signed({1'b0, quo_ff[NDIV-1][i]});
         end else begin
            u[i] = $signed({1'b0, quo_ff[NDIV-1][i]});
         end
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            lp_ff[i] <= u[i] * $signed(cfg.light[i]);
         end
         u0_ff <= u[0];
         u1_ff <= u[1];
      end
   end

   // Rounded dot product and the texture coordinates.
   logic signed [19:0] d_ff;
   logic [15:0]        cu_ff, cv_ff;
   always_ff @(posedge clock) begin
      logic signed [F+19:0] dot;
      logic signed [F+19:0] ds;
      logic signed [39:0]   c [2];
      logic [15:0]          cs [2];
      dot = (F + 20)'(lp_ff[0]) + (F + 20)'(lp_ff[1]) + (F + 20)'(lp_ff[2]) + HALF_D;
      ds  = dot >>> F;
      c[0] = (ONE_C - 40'(u0_ff) + 40'sd1) >>> 1;
      c[1] = (ONE_C - 40'(u1_ff) + 40'sd1) >>> 1;
      for (int i = 0; i < 2; i++) begin
         if (c[i] > 40'sd32767) begin
            cs[i] = 16'h7fff;
         end else if (c[i] < -40'sd32768) begin
            cs[i] = 16'h8000;
         end else begin
            cs[i] = c[i][15:0];
         end
      end
      if (advance) begin
         d_ff  <= ds[19:0];
         cu_ff <= side_ff[ST_P].chrome ? cs[0] : side_ff[ST_P].tex_u;
         cv_ff <= side_ff[ST_P].chrome ? cs[1] : side_ff[ST_P].tex_v;
      end
   end

   // Brightness, clamped to the range zero to one.
   logic [TCW-1:0] tc_ff;
   logic [15:0]    cu2_ff, cv2_ff;
   always_ff @(posedge clock) begin
      logic signed [36:0]   pg;
      logic signed [TW-1:0] t;
      logic [TCW-1:0]       tcl;
      pg = $signed({1'b0, cfg.diffuse}) * d_ff;
      t  = ($signed({1'b0, (TW - 1)'(cfg.ambient)}) <<< F) + (TW)'(pg);
      if (t < 0) begin
         tcl = '0;
      end else if (t > T_MAX) begin
         tcl = T_MAX[TCW-1:0];
      end else begin
         tcl = t[TCW-1:0];
      end
      if (advance) begin
         tc_ff  <= tcl;
         cu2_ff <= cu_ff;
         cv2_ff <= cv_ff;
      end
   end

   // Output stage: scale to eight bits.
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      logic [GW-1:0] g;
      g = ((GW)'(tc_ff) << 8) - (GW)'(tc_ff) + HALF_G;
      if (advance) begin
         rsp_ff.out_pos    <= side_ff[TOTAL-2].pos_sum;
         rsp_ff.gray_level <= g[F+23:F+16];
         rsp_ff.out_u      <= cu2_ff;
         rsp_ff.out_v      <= cv2_ff;
      end
   end
   assign rsp = rsp_ff;

endmodule

### hw/rtl/vertex_lambert_lighting_unit.sv
// The depth of the pipeline from an accepted req beat to its rsp beat is set
// by the 32 square root stages and the dividers, one quotient bit per stage.
// Throughput: one vertex per cycle; a stalled rsp beat holds the whole pipeline.
// Reset is synchronous: it clears all valid bits and loads the register defaults.
// Depends on vll_pkg and vll_datapath.
module vertex_lambert_lighting_unit #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
   // offset_x, offset_y, offset_z
   input  logic [271:0]                     req_tdata,
   // chrome
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_x, out_y, out_z, gray_level, out_u, out_v
   output logic [135:0]                     rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vll_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vll_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vll_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import vll_pkg::*;

   logic [47:0] row0_ff, row1_ff, row2_ff, light_ff;
   logic [15:0] amb_ff, dif_ff;
   logic [2:0]  idx;

   assign idx        = csr_paddr[5:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff  <= ROW_FIRST_RST;
         row1_ff  <= ROW_SECOND_RST;
         row2_ff  <= ROW_THIRD_RST;
         light_ff <= LIGHT_DIR_RST;
         amb_ff   <= AMBIENT_RST;
         dif_ff   <= DIFFUSE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_ROW_FIRST:  row0_ff  <= csr_pwdata[47:0];
            REG_ROW_SECOND: row1_ff  <= csr_pwdata[47:0];
            REG_ROW_THIRD:  row2_ff  <= csr_pwdata[47:0];
            REG_LIGHT_DIR:  light_ff <= csr_pwdata[47:0];
            REG_AMBIENT:    amb_ff   <= csr_pwdata[15:0];
            REG_DIFFUSE:    dif_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROW_FIRST:  csr_prdata = {16'd0, row0_ff};
         REG_ROW_SECOND: csr_prdata = {16'd0, row1_ff};
         REG_ROW_THIRD:  csr_prdata = {16'd0, row2_ff};
         REG_LIGHT_DIR:  csr_prdata = {16'd0, light_ff};
         REG_AMBIENT:    csr_prdata = {48'd0, amb_ff};
         REG_DIFFUSE:    csr_prdata = {48'd0, dif_ff};
         default:        csr_prdata = '0;
      endcase
   end

   cfg_type cfg;
   vtx_type vtx;
   rsp_type rsp;

   always_comb begin
      cfg.m       = {row2_ff, row1_ff, row0_ff};
      cfg.light   = light_ff;
      cfg.ambient = amb_ff;
      cfg.diffuse = dif_ff;
      vtx.pos[0]    = req_tdata[31:0];
      vtx.pos[1]    = req_tdata[63:32];
      vtx.pos[2]    = req_tdata[95:64];
      vtx.normal[0] = req_tdata[111:96];
      vtx.normal[1] = req_tdata[127:112];
      vtx.normal[2] = req_tdata[143:128];
      vtx.tex_u     = req_tdata[159:144];
      vtx.tex_v     = req_tdata[175:160];
      vtx.offset[0] = req_tdata[207:176];
      vtx.offset[1] = req_tdata[239:208];
      vtx.offset[2] = req_tdata[271:240];
      vtx.chrome    = req_tuser;
   end

   vll_datapath #(
      .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .vtx      (vtx),
      .cfg      (cfg),
      .out_ready(rsp_tready),
      .advance  (req_tready),
      .out_valid(rsp_tvalid),
      .rsp      (rsp)
   );

   assign rsp_tdata = {rsp.out_v, rsp.out_u, rsp.gray_level,
                       rsp.out_pos[2], rsp.out_pos[1], rsp.out_pos[0]};

endmodule

### hw/rtl/vll_checker.sv
// Port-level checks for the vertex Lambert lighting unit, bound to the top level.
// Depends only on the top level's port names.
module vll_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         csr_pready
);

   // A held result beat keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // A stalled output freezes the whole pipeline, so no req beat may enter.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while the pipeline is stalled");

   // With an empty output stage the pipeline always takes input.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req not ready with an empty output stage");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid || !req_tvalid |-> csr_pready)
      else $error("csr pready dropped");

endmodule

bind vertex_lambert_lighting_unit vll_checker u_vll_checker (.*);
